// File: design/pdu_pkg.sv
`timescale 1ns / 1ps

package pdu_pkg;

    // Field and state widths
    localparam int WORD_W   = 64;
    localparam int BYTE_W   = 8;
    localparam int LETTER_W = 8;
    localparam int CODE_W   = 4;
    localparam int POS_W    = 50;
    localparam int START_W  = 48;
    localparam int STOP_W   = 49;
    localparam int CFG_IDX_W = 3;

    // Bases held by a byte that is not final
    localparam logic [2:0] BASES_PER_BYTE = 3'd4;

    // Small entry layout (low 32 bits)
    localparam int SM_CODE_LSB  = 28;
    localparam int SM_COUNT_LSB = 24;
    localparam int SM_COUNT_W   = 4;
    localparam int SM_START_W   = 24;

    // Large entry layout
    localparam int LG_CODE_LSB  = 60;
    localparam int LG_COUNT_LSB = 48;
    localparam int LG_COUNT_W   = 12;

    typedef logic [LETTER_W-1:0] t_letter;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AMBIG_EN  = 3'd0,
        CFG_LARGE_FMT = 3'd1,
        CFG_BASE_TBL  = 3'd2,
        CFG_AMBIG_LO  = 3'd3,
        CFG_AMBIG_HI  = 3'd4
    } t_cfg_idx;

    // Input commands
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_BYTE = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                cmd;
        logic [WORD_W-1:0]   ambiguity_word;
        logic [BYTE_W-1:0]   packed_byte;
        logic                final_byte;
    } t_in_beat;

    typedef struct packed {
        t_letter letter;
        logic    last_of_byte;
        logic    sequence_end;
    } t_out_beat;

    typedef struct packed {
        logic ambig_en;
        logic large_fmt;
    } t_mode;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [START_W-1:0] start;
        logic [STOP_W-1:0]  stop;
    } t_run;

    typedef struct packed {
        logic busy;
        logic byte_pending;
        logic emit_end;
        logic pos_zero;
        logic wr_empty;
        logic idx_ok;
    } t_unpack_status;

    // Decode one ambiguity entry into code, first and last covered position
    function automatic t_run decode_entry(input logic [WORD_W-1:0] w, input logic large_fmt);
        t_run r;
        if (large_fmt) begin
            r.code  = w[LG_CODE_LSB +: CODE_W];
            r.start = w[START_W-1:0];
            r.stop  = {1'b0, r.start} + STOP_W'(w[LG_COUNT_LSB +: LG_COUNT_W]);
        end else begin
            r.code  = w[SM_CODE_LSB +: CODE_W];
            r.start = START_W'(w[SM_START_W-1:0]);
            r.stop  = {1'b0, r.start} + STOP_W'(w[SM_COUNT_LSB +: SM_COUNT_W]);
        end
        return r;
    endfunction

endpackage

// File: design/pdu_cfg_regs.sv
`timescale 1ns / 1ps

module pdu_cfg_regs #(
    parameter int LETTER_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [pdu_pkg::CFG_IDX_W-1:0]       i_wr_index,
    input  logic [pdu_pkg::WORD_W-1:0]          i_wr_data,
    output pdu_pkg::t_mode                      o_mode,
    output logic [3:0][LETTER_BITS-1:0]         o_base_tbl,
    output logic [15:0][LETTER_BITS-1:0]        o_ambig_tbl
);

    pdu_pkg::t_mode                 r_mode;
    logic [3:0][LETTER_BITS-1:0]    r_base_tbl;
    logic [15:0][LETTER_BITS-1:0]   r_ambig_tbl;

    // Capture register writes, keep only the letter bits of each byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= '0;
            r_base_tbl  <= '0;
            r_ambig_tbl <= '0;
        end else if (i_wr_en) begin
            case (i_wr_index)
                pdu_pkg::CFG_AMBIG_EN:  r_mode.ambig_en  <= i_wr_data[0];
                pdu_pkg::CFG_LARGE_FMT: r_mode.large_fmt <= i_wr_data[0];
                pdu_pkg::CFG_BASE_TBL: begin
                    for (int i = 0; i < 4; i++) begin
                        r_base_tbl[i] <= i_wr_data[8*i +: LETTER_BITS];
                    end
                end
                pdu_pkg::CFG_AMBIG_LO: begin
                    for (int i = 0; i < 8; i++) begin
                        r_ambig_tbl[i] <= i_wr_data[8*i +: LETTER_BITS];
                    end
                end
                pdu_pkg::CFG_AMBIG_HI: begin
                    for (int i = 0; i < 8; i++) begin
                        r_ambig_tbl[i+8] <= i_wr_data[8*i +: LETTER_BITS];
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_mode      = r_mode;
    assign o_base_tbl  = r_base_tbl;
    assign o_ambig_tbl = r_ambig_tbl;

endmodule

// File: design/pdu_entry_store.sv
`timescale 1ns / 1ps

module pdu_entry_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [pdu_pkg::WORD_W-1:0]  i_wr_data,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [pdu_pkg::WORD_W-1:0]  o_rd_data
);

    logic [pdu_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [pdu_pkg::WORD_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, new data forwarded on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/pdu_unpack.sv
`timescale 1ns / 1ps

module pdu_unpack #(
    parameter int DEPTH       = 256,
    parameter int AW          = 8,
    parameter int CW          = 9,
    parameter int LETTER_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  pdu_pkg::t_in_beat               i_in,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output pdu_pkg::t_out_beat              o_out,
    // configuration
    input  pdu_pkg::t_mode                  i_mode,
    input  logic [3:0][LETTER_BITS-1:0]     i_base_tbl,
    input  logic [15:0][LETTER_BITS-1:0]    i_ambig_tbl,
    // entry store
    output logic                            o_wr_en,
    output logic [AW-1:0]                   o_wr_addr,
    output logic [pdu_pkg::WORD_W-1:0]      o_wr_data,
    output logic [AW-1:0]                   o_rd_addr,
    input  logic [pdu_pkg::WORD_W-1:0]      i_rd_data,
    output pdu_pkg::t_unpack_status         o_status
);

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Registers
    logic                               r_busy, n_busy;
    pdu_pkg::t_in_beat                  r_item, n_item;
    logic [1:0]                         r_k, n_k;
    logic [pdu_pkg::POS_W-1:0]          r_pos, n_pos;
    pdu_pkg::t_run                      r_run, n_run;
    logic                               r_run_ok, n_run_ok;
    logic [CW-1:0]                      r_wr_cnt, n_wr_cnt;
    logic [CW-1:0]                      r_rd_idx, n_rd_idx;
    logic                               r_out_valid, n_out_valid;
    pdu_pkg::t_out_beat                 r_out, n_out;

    // Step control
    logic                               is_byte;
    logic [2:0]                         n_bases;
    logic                               empty_byte;
    logic                               last;
    logic                               out_free;
    logic                               step;
    logic                               emit;
    logic                               done;
    logic                               seq_end;
    logic                               in_acc;

    // Letter path
    logic [pdu_pkg::BYTE_W-1:0]         shifted;
    logic [1:0]                         base_code;
    logic                               take;
    logic                               avail;
    pdu_pkg::t_run                      cand;
    logic                               cov_old;
    logic                               cov_cand;
    logic                               covered;
    logic [pdu_pkg::CODE_W-1:0]         eff_code;
    logic [LETTER_BITS-1:0]             letter;

    // Decide what the held item does this cycle
    always_comb begin
        is_byte    = (r_item.cmd == pdu_pkg::CMD_BYTE);
        n_bases    = r_item.final_byte ? {1'b0, r_item.packed_byte[1:0]}
                                       : pdu_pkg::BASES_PER_BYTE;
        empty_byte = (n_bases == 3'd0);
        last       = (({1'b0, r_k} + 3'd1) == n_bases);
        out_free   = !r_out_valid || i_out_ready;
        step       = r_busy && (!is_byte || empty_byte || out_free);
        emit       = r_busy && is_byte && !empty_byte && out_free;
        done       = step && (!is_byte || empty_byte || last);
        seq_end    = done && is_byte && r_item.final_byte;
    end

    assign o_in_ready = !r_busy || done;
    assign in_acc     = i_in_valid && o_in_ready;

    // Pick the letter for the current base position
    always_comb begin
        shifted   = r_item.packed_byte << {r_k, 1'b0};
        base_code = shifted[7:6];
        avail     = (r_rd_idx < r_wr_cnt);
        take      = i_mode.ambig_en &&
                    ((r_pos == '0) || (r_pos > {1'b0, r_run.stop}));
        cand      = pdu_pkg::decode_entry(i_rd_data, i_mode.large_fmt);
        cov_old   = r_run_ok &&
                    (r_pos >= pdu_pkg::POS_W'(r_run.start)) &&
                    (r_pos <= pdu_pkg::POS_W'(r_run.stop));
        cov_cand  = (r_pos >= pdu_pkg::POS_W'(cand.start)) &&
                    (r_pos <= pdu_pkg::POS_W'(cand.stop));
        if (take) begin
            covered  = avail && cov_cand;
            eff_code = cand.code;
        end else begin
            covered  = cov_old;
            eff_code = r_run.code;
        end
        covered = covered && i_mode.ambig_en;
        letter  = covered ? i_ambig_tbl[eff_code] : i_base_tbl[base_code];
    end

    // Next state
    always_comb begin
        n_busy      = r_busy;
        n_item      = r_item;
        n_k         = r_k;
        n_pos       = r_pos;
        n_run       = r_run;
        n_run_ok    = r_run_ok;
        n_wr_cnt    = r_wr_cnt;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        o_wr_en   = 1'b0;
        o_wr_addr = r_wr_cnt[AW-1:0];
        o_wr_data = r_item.ambiguity_word;

        // drain the output register
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // store one entry
        if (step && !is_byte && (r_wr_cnt < DEPTH_C)) begin
            o_wr_en  = 1'b1;
            n_wr_cnt = r_wr_cnt + CW'(1);
        end

        // emit one letter and advance the run
        if (emit) begin
            n_out_valid        = 1'b1;
            n_out.letter       = pdu_pkg::t_letter'(letter);
            n_out.last_of_byte = last;
            n_out.sequence_end = last && r_item.final_byte;
            n_pos              = r_pos + pdu_pkg::POS_W'(1);
            n_k                = last ? 2'd0 : r_k + 2'd1;
            if (take) begin
                if (avail) begin
                    n_run    = cand;
                    n_run_ok = 1'b1;
                    n_rd_idx = r_rd_idx + CW'(1);
                end else begin
                    n_run_ok = 1'b0;
                end
            end
        end

        // clear sequence state after a final byte
        if (seq_end) begin
            n_pos    = '0;
            n_wr_cnt = '0;
            n_rd_idx = '0;
            n_run    = '0;
            n_run_ok = 1'b0;
        end

        // hold or refill the input register
        if (done) begin
            n_busy = 1'b0;
            n_k    = 2'd0;
        end
        if (in_acc) begin
            n_busy = 1'b1;
            n_item = i_in;
        end
    end

    assign o_rd_addr = n_rd_idx[AW-1:0];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_k         <= 2'd0;
            r_pos       <= '0;
            r_run       <= '0;
            r_run_ok    <= 1'b0;
            r_wr_cnt    <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_k         <= n_k;
            r_pos       <= n_pos;
            r_run       <= n_run;
            r_run_ok    <= n_run_ok;
            r_wr_cnt    <= n_wr_cnt;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_status.busy         = r_busy;
    assign o_status.byte_pending = r_busy && is_byte && !empty_byte;
    assign o_status.emit_end     = emit && last && r_item.final_byte;
    assign o_status.pos_zero     = (r_pos == '0);
    assign o_status.wr_empty     = (r_wr_cnt == '0);
    assign o_status.idx_ok       = (r_rd_idx <= r_wr_cnt);

endmodule

// File: design/packed_dna_unpack_with_ambiguity.sv
`timescale 1ns / 1ps

// Packed DNA unpacker with ambiguity runs.
// Input channel (i_in_valid / o_in_ready, payload i_in): a beat with cmd 0
// stores one ambiguity entry, a beat with cmd 1 carries one packed byte of
// four 2-bit bases, first base in bits 7..6. A final byte holds the number
// of bases given by its low two bits and closes the sequence, clearing the
// position, the stored entries and the current run.
// Result channel (o_out_valid / i_out_ready, payload o_out): one letter per
// beat, flagged on the last letter of each byte and of the sequence.
// Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index,
// i_cfg_data) is always ready; write it only while the block is idle.
// Timing: an accepted beat sits in the input register; a byte then yields
// one letter per cycle while the result port is not stalled, so it holds
// the unpacker until its last base is out (an entry load or an empty final
// byte does not wait on the result port). Each letter is registered in the
// output register. The next beat is taken in the cycle the current one
// finishes, so bytes stream back to back, bounded by the result port.
// A stalled receiver holds the output register and, once the next letter is
// due, the input register. Reset clears all control state and configuration.
module packed_dna_unpack_with_ambiguity #(
    parameter int ENTRY_DEPTH = 256,
    parameter int LETTER_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  pdu_pkg::t_in_beat               i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output pdu_pkg::t_out_beat              o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pdu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pdu_pkg::WORD_W-1:0]      i_cfg_data
);

    localparam int AW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int CW = $clog2(ENTRY_DEPTH + 1);

    pdu_pkg::t_mode                 mode;
    logic [3:0][LETTER_BITS-1:0]    base_tbl;
    logic [15:0][LETTER_BITS-1:0]   ambig_tbl;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [pdu_pkg::WORD_W-1:0]     wr_data;
    logic [AW-1:0]                  rd_addr;
    logic [pdu_pkg::WORD_W-1:0]     rd_data;
    pdu_pkg::t_unpack_status        status;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    pdu_cfg_regs #(
        .LETTER_BITS (LETTER_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (i_cfg_valid && o_cfg_ready),
        .i_wr_index  (i_cfg_index),
        .i_wr_data   (i_cfg_data),
        .o_mode      (mode),
        .o_base_tbl  (base_tbl),
        .o_ambig_tbl (ambig_tbl)
    );

    // Ambiguity entry memory
    pdu_entry_store #(
        .DEPTH (ENTRY_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Letter generation
    pdu_unpack #(
        .DEPTH       (ENTRY_DEPTH),
        .AW          (AW),
        .CW          (CW),
        .LETTER_BITS (LETTER_BITS)
    ) u_unpack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_mode      (mode),
        .i_base_tbl  (base_tbl),
        .i_ambig_tbl (ambig_tbl),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_status    (status)
    );

    // An accepted beat is held for processing
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> status.busy)
        else $error("accepted beat not held");

    // The last letter of a sequence leaves position and entries cleared
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.emit_end |=> (status.pos_zero && status.wr_empty))
        else $error("sequence state not cleared after final letter");

    // A pending letter blocks new input while the receiver stalls
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && status.byte_pending) |-> !o_in_ready)
        else $error("input taken while letter pending and output stalled");

    // Entries are never read past the loaded count
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.idx_ok)
        else $error("entry read index beyond write count");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int ENTRY_DEPTH  = 256;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_ITEMS  = 12;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    pdu_pkg::t_in_beat             i_in        = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    pdu_pkg::t_out_beat            o_out;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [pdu_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [pdu_pkg::WORD_W-1:0]    i_cfg_data  = '0;

    packed_dna_unpack_with_ambiguity #(
        .ENTRY_DEPTH(ENTRY_DEPTH),
        .LETTER_BITS(pdu_pkg::LETTER_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Mirror of the configuration registers
    logic                       m_ambig_en   = 1'b0;
    logic                       m_large      = 1'b0;
    logic [31:0]                m_base_tbl   = '0;
    logic [pdu_pkg::WORD_W-1:0] m_ambig_lo   = '0;
    logic [pdu_pkg::WORD_W-1:0] m_ambig_hi   = '0;

    // Mirror of the unpacker state
    logic [pdu_pkg::WORD_W-1:0]  entry_store [ENTRY_DEPTH];
    int                          wr_cnt      = 0;
    int                          rd_idx      = 0;
    logic [pdu_pkg::POS_W-1:0]   base_pos    = '0;
    logic [pdu_pkg::START_W-1:0] run_start   = '0;
    logic [pdu_pkg::STOP_W-1:0]  run_end     = '0;
    logic [pdu_pkg::CODE_W-1:0]  run_code    = '0;
    logic                        run_valid   = 1'b0;

    pdu_pkg::t_out_beat expected_letters [$];
    pdu_pkg::t_in_beat  pending_beats [$];
    pdu_pkg::t_out_beat want_beat;

    int pushed_cnt  = 0;
    int sent_cnt    = 0;
    int in_acc_cnt  = 0;
    int err_cnt     = 0;
    int cycle_cnt   = 0;
    int in_gap      = 0;
    int out_gap     = 0;
    int hold_left   = 0;
    bit idle_on     = 1'b1;
    bit stall_req   = 1'b0;
    bit stall_done  = 1'b0;

    // Work out the letters one accepted beat produces
    task automatic unpack_beat(input pdu_pkg::t_in_beat b);
        int                         nb;
        int                         k;
        logic [1:0]                 base;
        logic [pdu_pkg::WORD_W-1:0] w;
        logic [pdu_pkg::WORD_W-1:0] amb_tbl;
        pdu_pkg::t_out_beat         e;
        if (b.cmd == pdu_pkg::CMD_LOAD) begin
            // Drop loads once the store is full
            if (wr_cnt < ENTRY_DEPTH) begin
                entry_store[wr_cnt] = b.ambiguity_word;
                wr_cnt++;
            end
            return;
        end
        nb = b.final_byte ? int'(b.packed_byte[1:0]) : 4;
        for (k = 0; k < nb; k++) begin
            base = b.packed_byte[7-2*k -: 2];
            e.letter = m_base_tbl[base*8 +: 8];
            if (m_ambig_en) begin
                // Advance to the next run at the sequence start or past the run end
                if (base_pos == '0 || base_pos > pdu_pkg::POS_W'(run_end)) begin
                    if (rd_idx >= wr_cnt) begin
                        run_valid = 1'b0;
                    end else begin
                        w = entry_store[rd_idx];
                        rd_idx++;
                        if (m_large) begin
                            run_code  = w[pdu_pkg::LG_CODE_LSB +: pdu_pkg::CODE_W];
                            run_start = w[pdu_pkg::START_W-1:0];
                            run_end   = pdu_pkg::STOP_W'(w[pdu_pkg::START_W-1:0])
                                        + pdu_pkg::STOP_W'(
                                            w[pdu_pkg::LG_COUNT_LSB +: pdu_pkg::LG_COUNT_W]);
                        end else begin
                            run_code  = w[pdu_pkg::SM_CODE_LSB +: pdu_pkg::CODE_W];
                            run_start = pdu_pkg::START_W'(w[pdu_pkg::SM_START_W-1:0]);
                            run_end   = pdu_pkg::STOP_W'(w[pdu_pkg::SM_START_W-1:0])
                                        + pdu_pkg::STOP_W'(
                                            w[pdu_pkg::SM_COUNT_LSB +: pdu_pkg::SM_COUNT_W]);
                        end
                        run_valid = 1'b1;
                    end
                end
                if (run_valid && base_pos >= pdu_pkg::POS_W'(run_start)
                        && base_pos <= pdu_pkg::POS_W'(run_end)) begin
                    amb_tbl  = run_code[3] ? m_ambig_hi : m_ambig_lo;
                    e.letter = amb_tbl[run_code[2:0]*8 +: 8];
                end
            end
            e.last_of_byte = (k == nb - 1);
            e.sequence_end = b.final_byte && (k == nb - 1);
            expected_letters.push_back(e);
            base_pos = base_pos + 1'b1;
        end
        // Clear position, entries and run at the end of a sequence
        if (b.final_byte) begin
            base_pos  = '0;
            wr_cnt    = 0;
            rd_idx    = 0;
            run_start = '0;
            run_end   = '0;
            run_code  = '0;
            run_valid = 1'b0;
        end
    endtask

    // Sample all three channels at the rising edge
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    pdu_pkg::CFG_AMBIG_EN:  m_ambig_en = i_cfg_data[0];
                    pdu_pkg::CFG_LARGE_FMT: m_large    = i_cfg_data[0];
                    pdu_pkg::CFG_BASE_TBL:  m_base_tbl = i_cfg_data[31:0];
                    pdu_pkg::CFG_AMBIG_LO:  m_ambig_lo = i_cfg_data;
                    pdu_pkg::CFG_AMBIG_HI:  m_ambig_hi = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_letters.size() == 0) begin
                    err_cnt++;
                    $error("unexpected letter beat: actual %0h", o_out.letter);
                end else begin
                    want_beat = expected_letters.pop_front();
                    if (o_out.letter !== want_beat.letter) begin
                        err_cnt++;
                        $error("letter: expected %0h, actual %0h",
                               want_beat.letter, o_out.letter);
                    end
                    if (o_out.last_of_byte !== want_beat.last_of_byte) begin
                        err_cnt++;
                        $error("last_of_byte: expected %0b, actual %0b",
                               want_beat.last_of_byte, o_out.last_of_byte);
                    end
                    if (o_out.sequence_end !== want_beat.sequence_end) begin
                        err_cnt++;
                        $error("sequence_end: expected %0b, actual %0b",
                               want_beat.sequence_end, o_out.sequence_end);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                unpack_beat(i_in);
                in_acc_cnt++;
            end
        end
    end

    // Present pending beats, hold each until accepted, idle in bursts
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_acc_cnt == sent_cnt)) begin
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                i_in       <= pending_beats.pop_front();
                i_in_valid <= 1'b1;
                sent_cnt++;
                if (idle_on && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 19);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Stall the result side in bursts, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (stall_req && !stall_done) begin
            stall_done = 1'b1;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_gap = $urandom_range(0, 18);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input pdu_pkg::t_cfg_idx idx,
                             input logic [pdu_pkg::WORD_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic write_config(input logic en, input logic large_fmt,
                                input logic [31:0] base_tbl,
                                input logic [pdu_pkg::WORD_W-1:0] amb_lo,
                                input logic [pdu_pkg::WORD_W-1:0] amb_hi);
        write_reg(pdu_pkg::CFG_AMBIG_EN,  pdu_pkg::WORD_W'(en));
        write_reg(pdu_pkg::CFG_LARGE_FMT, pdu_pkg::WORD_W'(large_fmt));
        write_reg(pdu_pkg::CFG_BASE_TBL,  pdu_pkg::WORD_W'(base_tbl));
        write_reg(pdu_pkg::CFG_AMBIG_LO,  amb_lo);
        write_reg(pdu_pkg::CFG_AMBIG_HI,  amb_hi);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every beat is taken and every letter has come, then a bit more
    task automatic settle();
        while (in_acc_cnt != pushed_cnt || expected_letters.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_load(input logic [pdu_pkg::WORD_W-1:0] w);
        pdu_pkg::t_in_beat b;
        b.cmd            = pdu_pkg::CMD_LOAD;
        b.ambiguity_word = w;
        b.packed_byte    = 8'($urandom);
        b.final_byte     = 1'($urandom);
        pending_beats.push_back(b);
        pushed_cnt++;
    endtask

    task automatic add_byte(input logic [pdu_pkg::BYTE_W-1:0] pb, input logic fin);
        pdu_pkg::t_in_beat b;
        b.cmd            = pdu_pkg::CMD_BYTE;
        b.ambiguity_word = {$urandom, $urandom};
        b.packed_byte    = pb;
        b.final_byte     = fin;
        pending_beats.push_back(b);
        pushed_cnt++;
    endtask

    function automatic logic [pdu_pkg::WORD_W-1:0] entry_word(
            input logic large_fmt, input logic [pdu_pkg::CODE_W-1:0] code,
            input int cnt, input int start);
        if (large_fmt) return {code, 12'(cnt), 48'(start)};
        return {32'($urandom), code, 4'(cnt), 24'(start)};
    endfunction

    // One sequence: ascending runs, stray words, bytes, late loads, final byte
    task automatic gen_sequence(input logic large_fmt);
        int n_ent;
        int n_bytes;
        int cur;
        int cnt;
        int i;
        n_ent = $urandom_range(0, 5);
        cur   = $urandom_range(0, 6);
        for (i = 0; i < n_ent; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                add_load({$urandom, $urandom});
            end else begin
                if (large_fmt)
                    cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 4095)
                                                       : $urandom_range(0, 12);
                else
                    cnt = $urandom_range(0, 15);
                add_load(entry_word(large_fmt, 4'($urandom), cnt, cur));
                cur += cnt + $urandom_range(1, 8);
            end
        end
        n_bytes = $urandom_range(0, 10);
        for (i = 0; i < n_bytes; i++) begin
            if ($urandom_range(0, 7) == 0)
                add_load(entry_word(large_fmt, 4'($urandom), $urandom_range(0, 4),
                                    i * 4 + $urandom_range(0, 12)));
            add_byte(8'($urandom), 1'b0);
        end
        add_byte(8'($urandom), 1'b1);
    endtask

    task automatic random_phase(input int n_items, input logic large_fmt);
        int target;
        target = pushed_cnt + n_items;
        while (pushed_cnt < target) gen_sequence(large_fmt);
    endtask

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int i;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Small layout: runs at the start, exhaustion, a late load, short finals
        write_config(1'b1, 1'b0, 32'h5447_4341,
                     64'h6867_6665_6463_6261, 64'h7071_7273_7475_7677);
        add_load(entry_word(1'b0, 4'h0, 0, 0));
        add_load(entry_word(1'b0, 4'hf, 15, 2));
        add_byte(8'h00, 1'b0);
        add_byte(8'hff, 1'b0);
        add_byte(8'h1b, 1'b0);
        add_byte(8'he4, 1'b0);
        add_load(entry_word(1'b0, 4'h5, 3, 20));
        add_byte(8'h6c, 1'b0);
        add_byte(8'h93, 1'b0);
        add_byte(8'ha3, 1'b1);
        // Empty final byte, then one- and two-base sequences
        add_byte(8'h00, 1'b1);
        add_byte(8'h01, 1'b1);
        add_byte(8'h02, 1'b1);
        settle();

        // Large layout: longest run, all-ones word, extreme tables
        write_config(1'b1, 1'b1, 32'hffff_ffff, 64'h0,
                     64'h5a5a_c3c3_1234_fedc);
        add_load(entry_word(1'b1, 4'h9, 4095, 0));
        add_load({pdu_pkg::WORD_W{1'b1}});
        add_byte(8'h5a, 1'b0);
        add_byte(8'h27, 1'b1);
        settle();

        // Ambiguity off: loads are stored but never applied
        write_config(1'b0, 1'b1, 32'h0123_4567, {pdu_pkg::WORD_W{1'b1}},
                     {pdu_pkg::WORD_W{1'b1}});
        add_load(entry_word(1'b1, 4'h3, 10, 0));
        add_byte(8'hc6, 1'b0);
        add_byte(8'hc2, 1'b1);
        settle();

        write_config(1'b1, 1'b0, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        random_phase(PHASE_ITEMS, 1'b0);
        settle();

        // Long hold-off on the result side while beats keep coming
        write_config(1'b1, 1'b1, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        random_phase(PHASE_ITEMS, 1'b1);
        stall_req = 1'b1;
        settle();

        write_config(1'b0, 1'($urandom), $urandom, {$urandom, $urandom},
                     {$urandom, $urandom});
        random_phase(PHASE_ITEMS, 1'b0);
        settle();

        write_config(1'b1, 1'b0, 32'h0, {pdu_pkg::WORD_W{1'b1}}, 64'h0);
        random_phase(PHASE_ITEMS, 1'b0);
        settle();

        // Overfill the store, then walk past every entry
        write_config(1'b1, 1'b0, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        for (i = 0; i < ENTRY_DEPTH + 4; i++) add_load(entry_word(1'b0, 4'($urandom), 0, i));
        for (i = 0; i < 66; i++) add_byte(8'($urandom), 1'b0);
        add_byte(8'h00, 1'b1);
        settle();

        write_config(1'b1, 1'b1, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        random_phase(PHASE_ITEMS, 1'b1);
        settle();

        // Closing stretch at full rate
        idle_on = 1'b0;
        in_gap  = 0;
        out_gap = 0;
        write_config(1'b1, 1'b0, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        random_phase(PHASE_ITEMS, 1'b0);
        settle();

        write_config(1'b1, 1'b1, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        random_phase(PHASE_ITEMS, 1'b1);
        settle();

        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/pdu_pkg.sv
design/pdu_cfg_regs.sv
design/pdu_entry_store.sv
design/pdu_unpack.sv
design/packed_dna_unpack_with_ambiguity.sv
sim/tb.sv
